// ===== hw/rtl/gcs_pkg.sv =====
// Shared types, constants and codes for the gait contact scheduler.
`default_nettype none

package gcs_pkg;

  localparam int MAX_INTERVALS_DEF   = 4;
  localparam int PHASE_FRAC_BITS_DEF = 16;

  localparam int NUM_SWITCH   = 4;
  localparam int Q16_W        = 17;
  localparam int Q16_FRAC     = 16;
  localparam int TS_W         = 20;
  localparam int RATE_W       = 16;
  localparam int LEN_W        = 3;
  localparam int PAT_W        = 4;
  localparam int POS_W        = 2;
  localparam int PHASE_OUT_W  = 20;
  localparam int RATE_SCALE   = 28;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 17;

  localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;

  localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LENGTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_STATES  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH_TIME_0   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH_TIME_1   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH_TIME_2   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH_TIME_3   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_EARLY_THRESHOLD = 3'd6;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST  = 3'd2;
  localparam logic [PAT_W-1:0] PATTERN_STATES_RST  = 4'd2;
  localparam logic [Q16_W-1:0] SWITCH_TIME_0_RST   = 17'd32768;
  localparam logic [Q16_W-1:0] SWITCH_TIME_N_RST   = 17'd65536;
  localparam logic [Q16_W-1:0] EARLY_THRESHOLD_RST = 17'd58982;

  typedef struct packed {
    logic [TS_W-1:0]   time_step;
    logic [RATE_W-1:0] gait_rate;
    logic              contact_flag;
    logic [TS_W-1:0]   lookahead_time;
    logic              restart;
  } in_word_t;

  typedef struct packed {
    logic                   contact_state;
    logic [PHASE_OUT_W-1:0] phase_out;
    logic [Q16_W-1:0]       progress;
    logic [POS_W-1:0]       pattern_position;
    logic                   predicted_state;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PHASE,
    ST_CHECK,
    ST_DIV1,
    ST_ADV,
    ST_PROG,
    ST_DIV2,
    ST_PRED,
    ST_SCAN,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic phase_upd;
    logic div_start;
    logic adv;
    logic prog_store;
    logic pred_init;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic leg;
    logic stance_done;
    logic swing_done;
    logic div_done;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gait_contact_scheduler.sv =====
// Top level of the gait contact scheduler: controller plus datapath.
//
//  port group | dir | handshake           | word
//  in_*       | in  | in_valid / in_stall  | gcs_pkg::in_word_t
//  out_*      | out | out_valid / out_stall| gcs_pkg::out_word_t
//  cfg_*      | in  | cfg_we               | cfg_addr, cfg_wdata
//
// One word at a time, with an advance step on an interval change and a look-ahead scan of
// s scan steps, where s is 1 to MAX_INTERVALS + 1.
// The 16-step progress divider runs once in stance, twice in swing.
// Reset is synchronous; controller state, config, gait state and out_valid reset.
// A stalled result holds in the output register; the next word is taken meanwhile.
`default_nettype none

module gait_contact_scheduler #(
  parameter int MAX_INTERVALS   = gcs_pkg::MAX_INTERVALS_DEF,
  parameter int PHASE_FRAC_BITS = gcs_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gcs_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gcs_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [gcs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcs_dp #(
    .MAX_INTERVALS   (MAX_INTERVALS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gcs_div.sv =====
// Sequential progress divider: clamped Q16 fraction of two signed differences.
`default_nettype none

module gcs_div #(
  parameter int SW = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic signed [SW-1:0]        num_i,
  input  logic signed [SW-1:0]        den_i,
  output logic                        done_o,
  output logic [gcs_pkg::Q16_W-1:0]   quo_o
);
  import gcs_pkg::*;

  localparam int MW = SW - 1;
  localparam int CW = $clog2(Q16_FRAC + 1);

  logic                busy_r;
  logic [CW-1:0]       cnt_r;
  logic [MW-1:0]       rem_r;
  logic [MW-1:0]       dvs_r;
  logic [Q16_FRAC-1:0] quo_r;
  logic                spec_r;
  logic [Q16_W-1:0]    spec_val_r;

  logic signed [SW-1:0] n_s;
  logic signed [SW-1:0] d_s;
  logic                 spec;
  logic [Q16_W-1:0]     spec_val;
  logic [MW:0]          rem_sh;
  logic                 ge;
  logic [MW:0]          rem_sub;

  // fold the sign into the numerator, then sort out the clamped cases
  always_comb begin
    n_s      = den_i[SW-1] ? -num_i : num_i;
    d_s      = den_i[SW-1] ? -den_i : den_i;
    spec     = 1'b1;
    spec_val = '0;
    if (den_i == '0) begin
      spec_val = (!num_i[SW-1] && num_i != '0) ? Q16_ONE : '0;
    end else if (n_s[SW-1] || n_s == '0) begin
      spec_val = '0;
    end else if (n_s >= d_s) begin
      spec_val = Q16_ONE;
    end else begin
      spec = 1'b0;
    end
  end

  assign rem_sh  = {rem_r, 1'b0};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(Q16_FRAC);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r      <= n_s[MW-1:0];
      dvs_r      <= d_s[MW-1:0];
      quo_r      <= '0;
      spec_r     <= spec;
      spec_val_r <= spec_val;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
      quo_r <= {quo_r[Q16_FRAC-2:0], ge};
    end
  end

  assign done_o = busy_r && (cnt_r == '0);
  assign quo_o  = spec_r ? spec_val_r : {1'b0, quo_r};

endmodule

`default_nettype wire

// ===== hw/rtl/gcs_dp.sv =====
// Datapath: configuration, gait state, multipliers, progress, look-ahead scan, output word.
`default_nettype none

module gcs_dp #(
  parameter int MAX_INTERVALS   = gcs_pkg::MAX_INTERVALS_DEF,
  parameter int PHASE_FRAC_BITS = gcs_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gcs_pkg::in_word_t                in_data,
  input  logic                             cfg_we,
  input  logic [gcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  gcs_pkg::cmd_t                    cmd,
  output gcs_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gcs_pkg::out_word_t               out_data
);
  import gcs_pkg::*;

  localparam int PFB        = PHASE_FRAC_BITS;
  localparam int PW         = PFB + 4;
  localparam int EPW        = PFB + 1;
  localparam int SW         = PW + 1;
  localparam int RATE_SHIFT = RATE_SCALE - PFB;
  localparam int PROD_W     = TS_W + RATE_W;
  localparam int INC_W      = PROD_W - RATE_SHIFT;
  localparam int SUM_W      = INC_W + 1;
  localparam int CNT_W      = ($clog2(MAX_INTERVALS + 1) > LEN_W) ?
                              $clog2(MAX_INTERVALS + 1) : LEN_W;
  localparam int IDX_W      = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

  localparam logic [PW-1:0]    PH_ONE = PW'(1) << PFB;
  localparam logic [PW-1:0]    PH_MAX = '1;
  localparam logic [CNT_W-1:0] N_MAX  = CNT_W'(MAX_INTERVALS);

  // configuration registers
  logic [LEN_W-1:0] len_r;
  logic [PAT_W-1:0] pat_r;
  logic [Q16_W-1:0] sw_r [NUM_SWITCH];
  logic [Q16_W-1:0] thr_r;

  // gait state
  logic [PW-1:0]    phase_r;
  logic [PW-1:0]    start_r;
  logic [Q16_W-1:0] end_r;
  logic [IDX_W-1:0] idx_r;
  logic             leg_r;

  // per-word working registers
  logic [TS_W-1:0]   ts_r;
  logic [RATE_W-1:0] rate_r;
  logic              contact_r;
  logic [TS_W-1:0]   ahead_r;
  logic [PROD_W-1:0] prod1_r;
  logic [PROD_W-1:0] prod2_r;
  logic [Q16_W-1:0]  prog_r;
  logic [EPW-1:0]    pf_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              pred_r;
  logic              out_valid_r;
  out_word_t         out_r;

  logic [CNT_W-1:0]     n_used;
  logic [CNT_W-1:0]     idx_ext;
  logic [CNT_W-1:0]     nxt_raw;
  logic                 wrap;
  logic [CNT_W-1:0]     nxt;
  logic [PW-1:0]        ph_adv;
  logic [CNT_W-1:0]     tab_idx;
  logic [Q16_W-1:0]     tab_end;
  logic                 tab_state;
  logic [EPW-1:0]       endp_cur;
  logic [SUM_W-1:0]     ph_sum;
  logic [PW-1:0]        ph_sat;
  logic [SUM_W-1:0]     p_sum;
  logic [SUM_W-1:0]     p_m1;
  logic [EPW-1:0]       pf_nxt;
  logic signed [SW-1:0] div_num;
  logic signed [SW-1:0] div_den;
  logic                 div_done;
  logic [Q16_W-1:0]     div_quo;
  logic                 scan_end;
  logic                 scan_hit;

  function automatic logic [EPW-1:0] to_phase(input logic [Q16_W-1:0] t);
    logic [Q16_W+PFB-1:0] tw;
    tw = {t, {PFB{1'b0}}};
    return tw[Q16_W+PFB-1:Q16_FRAC];
  endfunction

  function automatic logic [Q16_W-1:0] end_sel(input logic [CNT_W-1:0] i);
    logic [Q16_W-1:0] r;
    r = Q16_ONE;
    if (i < CNT_W'(NUM_SWITCH)) begin
      r = sw_r[i[1:0]];
    end
    return r;
  endfunction

  function automatic logic state_sel(input logic [CNT_W-1:0] i);
    logic r;
    r = 1'b0;
    if (i < CNT_W'(NUM_SWITCH)) begin
      r = pat_r[i[1:0]];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= PATTERN_LENGTH_RST;
      pat_r <= PATTERN_STATES_RST;
      sw_r[0] <= SWITCH_TIME_0_RST;
      sw_r[1] <= SWITCH_TIME_N_RST;
      sw_r[2] <= SWITCH_TIME_N_RST;
      sw_r[3] <= SWITCH_TIME_N_RST;
      thr_r <= EARLY_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PATTERN_LENGTH:  len_r   <= cfg_wdata[LEN_W-1:0];
        CFG_PATTERN_STATES:  pat_r   <= cfg_wdata[PAT_W-1:0];
        CFG_SWITCH_TIME_0:   sw_r[0] <= cfg_wdata;
        CFG_SWITCH_TIME_1:   sw_r[1] <= cfg_wdata;
        CFG_SWITCH_TIME_2:   sw_r[2] <= cfg_wdata;
        CFG_SWITCH_TIME_3:   sw_r[3] <= cfg_wdata;
        CFG_EARLY_THRESHOLD: thr_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      n_used = CNT_W'(1);
    end else if (CNT_W'(len_r) > N_MAX) begin
      n_used = N_MAX;
    end else begin
      n_used = CNT_W'(len_r);
    end
  end

  // next interval and the single table read shared by advance and scan
  assign idx_ext   = CNT_W'(idx_r);
  assign nxt_raw   = idx_ext + CNT_W'(1);
  assign wrap      = nxt_raw >= n_used;
  assign nxt       = wrap ? '0 : nxt_raw;
  assign ph_adv    = !wrap ? phase_r : ((phase_r >= PH_ONE) ? phase_r - PH_ONE : '0);
  assign tab_idx   = cmd.adv ? nxt : scan_cnt_r;
  assign tab_end   = end_sel(tab_idx);
  assign tab_state = state_sel(tab_idx);
  assign endp_cur  = to_phase(end_r);

  assign ph_sum = SUM_W'(phase_r) + SUM_W'(prod1_r[PROD_W-1:RATE_SHIFT]);
  assign ph_sat = (ph_sum > SUM_W'(PH_MAX)) ? PH_MAX : ph_sum[PW-1:0];

  assign p_sum  = SUM_W'(phase_r) + SUM_W'(prod2_r[PROD_W-1:RATE_SHIFT]);
  assign p_m1   = p_sum - SUM_W'(1);
  assign pf_nxt = (p_sum > SUM_W'(PH_ONE)) ? (EPW'(p_m1[PFB-1:0]) + EPW'(1)) :
                  p_sum[EPW-1:0];

  assign div_num = $signed({1'b0, phase_r}) - $signed({1'b0, start_r});
  assign div_den = $signed({{(SW-EPW){1'b0}}, endp_cur}) - $signed({1'b0, start_r});

  gcs_div #(
    .SW (SW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      start_r <= '0;
      end_r   <= SWITCH_TIME_0_RST;
      idx_r   <= '0;
      leg_r   <= PATTERN_STATES_RST[0];
    end else if (cmd.load && in_data.restart) begin
      phase_r <= '0;
      start_r <= '0;
      end_r   <= sw_r[0];
      idx_r   <= '0;
      leg_r   <= pat_r[0];
    end else if (cmd.phase_upd) begin
      phase_r <= ph_sat;
    end else if (cmd.adv) begin
      phase_r <= ph_adv;
      start_r <= ph_adv;
      end_r   <= tab_end;
      idx_r   <= nxt[IDX_W-1:0];
      leg_r   <= tab_state;
    end
  end

  assign scan_end = scan_cnt_r >= n_used;
  assign scan_hit = pf_r <= to_phase(tab_end);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_r      <= in_data.time_step;
      rate_r    <= in_data.gait_rate;
      contact_r <= in_data.contact_flag;
      ahead_r   <= in_data.lookahead_time;
    end
    if (cmd.mul) begin
      prod1_r <= PROD_W'(ts_r) * PROD_W'(rate_r);
      prod2_r <= PROD_W'(ahead_r) * PROD_W'(rate_r);
    end
    if (cmd.prog_store) begin
      prog_r <= div_quo;
    end
    if (cmd.pred_init) begin
      pf_r       <= pf_nxt;
      scan_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      if (scan_end) begin
        pred_r <= 1'b0;
      end else if (scan_hit) begin
        pred_r <= tab_state;
      end else begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
    end
    if (cmd.out_load) begin
      out_r.contact_state    <= leg_r;
      out_r.phase_out        <= PHASE_OUT_W'(phase_r);
      out_r.progress         <= prog_r;
      out_r.pattern_position <= idx_ext[POS_W-1:0];
      out_r.predicted_state  <= pred_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.leg         = leg_r;
    sts.stance_done = phase_r >= PW'(endp_cur);
    sts.swing_done  = ((div_quo > thr_r) && contact_r) || div_quo[Q16_FRAC];
    sts.div_done    = div_done;
    sts.scan_done   = scan_end || scan_hit;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gcs_ctrl.sv =====
// Controller state machine that sequences one tick through the datapath.
`default_nettype none

module gcs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gcs_pkg::sts_t  sts,
  output gcs_pkg::cmd_t  cmd
);
  import gcs_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_PHASE;
      ST_PHASE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.leg) begin
          state_nxt = ST_DIV1;
        end else begin
          state_nxt = sts.stance_done ? ST_ADV : ST_PROG;
        end
      end
      ST_DIV1:  if (sts.div_done) state_nxt = sts.swing_done ? ST_ADV : ST_PROG;
      ST_ADV:   state_nxt = ST_PROG;
      ST_PROG:  state_nxt = ST_DIV2;
      ST_DIV2:  if (sts.div_done) state_nxt = ST_PRED;
      ST_PRED:  state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.scan_done) state_nxt = ST_OUT;
      ST_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL:   cmd.mul = 1'b1;
      ST_PHASE: cmd.phase_upd = 1'b1;
      ST_CHECK: cmd.div_start = sts.leg;
      ST_DIV1:  ;
      ST_ADV:   cmd.adv = 1'b1;
      ST_PROG:  cmd.div_start = 1'b1;
      ST_DIV2:  cmd.prog_store = sts.div_done;
      ST_PRED:  cmd.pred_init = 1'b1;
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_OUT:   cmd.out_load = sts.out_free;
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gcs_checker.sv =====
// Port-level checks for the gait contact scheduler, bound to the top level.
`default_nettype none

module gcs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input gcs_pkg::out_word_t out_data
);
  import gcs_pkg::*;

  // one word in flight: stall the input right after an accept
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.progress <= Q16_ONE))
    else $error("progress above one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind gait_contact_scheduler gcs_checker u_gcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/gait_contact_scheduler_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the gait contact scheduler: directed and random ticks.
module gait_contact_scheduler_test;
  import gcs_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 64;
  localparam int RATE_SHIFT  = RATE_SCALE - PHASE_FRAC_BITS_DEF;
  localparam logic [CFG_ADDR_W-1:0]  CFG_UNUSED = 3'd7;
  localparam logic [PHASE_OUT_W-1:0] PHASE_SAT  = 20'hFFFFF;
  localparam logic [PHASE_OUT_W-1:0] PHASE_ONE  = 20'h10000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gait_contact_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [LEN_W-1:0]       g_len;
  logic [PAT_W-1:0]       g_states;
  logic [Q16_W-1:0]       g_switch [NUM_SWITCH];
  logic [Q16_W-1:0]       g_thresh;
  logic [PHASE_OUT_W-1:0] g_phase;
  logic [PHASE_OUT_W-1:0] g_start;
  logic [Q16_W-1:0]       g_end;
  logic [POS_W-1:0]       g_idx;
  logic                   g_leg;

  out_word_t pending_words[$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  int        stall_left  = 0;
  bit        calm        = 1'b0;

  function automatic int used_intervals();
    int n;
    n = int'(g_len);
    if (n < 1) n = 1;
    if (n > MAX_INTERVALS_DEF) n = MAX_INTERVALS_DEF;
    return n;
  endfunction

  function automatic logic [Q16_W-1:0] interval_progress();
    longint num;
    longint den;
    num = longint'(g_phase) - longint'(g_start);
    den = longint'(g_end) - longint'(g_start);
    if (den == 0) return (num > 0) ? Q16_ONE : '0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return '0;
    if (num >= den) return Q16_ONE;
    return Q16_W'((num * 65536) / den);
  endfunction

  function automatic void advance_interval();
    int nxt;
    nxt = int'(g_idx) + 1;
    if (nxt >= used_intervals()) begin
      nxt = 0;
      g_phase = (g_phase >= PHASE_ONE) ? g_phase - PHASE_ONE : '0;
    end
    g_idx   = POS_W'(nxt);
    g_start = g_phase;
    g_end   = g_switch[nxt];
    g_leg   = g_states[nxt];
  endfunction

  function automatic void restart_gait();
    g_phase = '0;
    g_start = '0;
    g_idx   = '0;
    g_end   = g_switch[0];
    g_leg   = g_states[0];
  endfunction

  function automatic void reset_gait();
    g_len       = PATTERN_LENGTH_RST;
    g_states    = PATTERN_STATES_RST;
    g_switch[0] = SWITCH_TIME_0_RST;
    g_switch[1] = SWITCH_TIME_N_RST;
    g_switch[2] = SWITCH_TIME_N_RST;
    g_switch[3] = SWITCH_TIME_N_RST;
    g_thresh    = EARLY_THRESHOLD_RST;
    restart_gait();
  endfunction

  function automatic logic predict_leg(input logic [TS_W-1:0] ahead,
                                       input logic [RATE_W-1:0] rate);
    longint p;
    p = longint'(g_phase) + ((longint'(ahead) * longint'(rate)) >> RATE_SHIFT);
    if (p > 65536) p = ((p - 1) % 65536) + 1;
    for (int i = 0; i < used_intervals(); i++)
      if (p <= longint'(g_switch[i])) return g_states[i];
    return 1'b0;
  endfunction

  function automatic out_word_t tick_gait(input in_word_t w);
    longint           ph;
    logic [Q16_W-1:0] prog;
    out_word_t        r;
    if (w.restart) restart_gait();
    ph = longint'(g_phase) + ((longint'(w.time_step) * longint'(w.gait_rate)) >> RATE_SHIFT);
    g_phase = (ph > longint'(PHASE_SAT)) ? PHASE_SAT : PHASE_OUT_W'(ph);
    if (!g_leg) begin
      if (g_phase >= g_end) advance_interval();
    end else begin
      prog = interval_progress();
      if ((prog > g_thresh && w.contact_flag) || prog >= Q16_ONE) advance_interval();
    end
    r.contact_state    = g_leg;
    r.phase_out        = g_phase;
    r.progress         = interval_progress();
    r.pattern_position = g_idx;
    r.predicted_state  = predict_leg(w.lookahead_time, w.gait_rate);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_stall && !calm) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: state %0d phase %0d progress %0d position %0d predicted %0d",
                   out_data.contact_state, out_data.phase_out, out_data.progress,
                   out_data.pattern_position, out_data.predicted_state);
      end else begin
        want = pending_words.pop_front();
        if (out_data.contact_state !== want.contact_state ||
            out_data.phase_out !== want.phase_out ||
            out_data.progress !== want.progress ||
            out_data.pattern_position !== want.pattern_position ||
            out_data.predicted_state !== want.predicted_state) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected: state %0d phase %0d progress %0d position %0d predicted %0d",
                     want.contact_state, want.phase_out, want.progress,
                     want.pattern_position, want.predicted_state);
            $display("actual:   state %0d phase %0d progress %0d position %0d predicted %0d",
                     out_data.contact_state, out_data.phase_out, out_data.progress,
                     out_data.pattern_position, out_data.predicted_state);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_words = {pending_words, tick_gait(w)};
  endtask

  task automatic tick(input logic [TS_W-1:0] ts, input logic [RATE_W-1:0] rate,
                      input logic touch, input logic [TS_W-1:0] ahead, input logic again);
    in_word_t w;
    w.time_step      = ts;
    w.gait_rate      = rate;
    w.contact_flag   = touch;
    w.lookahead_time = ahead;
    w.restart        = again;
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      CFG_PATTERN_LENGTH:  g_len = data[LEN_W-1:0];
      CFG_PATTERN_STATES:  g_states = data[PAT_W-1:0];
      CFG_SWITCH_TIME_0, CFG_SWITCH_TIME_1, CFG_SWITCH_TIME_2, CFG_SWITCH_TIME_3:
        g_switch[addr - CFG_SWITCH_TIME_0] = data;
      CFG_EARLY_THRESHOLD: g_thresh = data;
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [CFG_DATA_W-1:0] len,
                             input logic [CFG_DATA_W-1:0] states,
                             input logic [CFG_DATA_W-1:0] t0,
                             input logic [CFG_DATA_W-1:0] t1,
                             input logic [CFG_DATA_W-1:0] t2,
                             input logic [CFG_DATA_W-1:0] t3,
                             input logic [CFG_DATA_W-1:0] thr);
    cfg_write(CFG_PATTERN_LENGTH, len);
    cfg_write(CFG_PATTERN_STATES, states);
    cfg_write(CFG_SWITCH_TIME_0, t0);
    cfg_write(CFG_SWITCH_TIME_1, t1);
    cfg_write(CFG_SWITCH_TIME_2, t2);
    cfg_write(CFG_SWITCH_TIME_3, t3);
    cfg_write(CFG_EARLY_THRESHOLD, thr);
    cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_gait_setup();
    int                    n;
    int                    acc;
    logic [CFG_DATA_W-1:0] t [NUM_SWITCH];
    n   = $urandom_range(1, NUM_SWITCH);
    acc = 0;
    for (int i = 0; i < NUM_SWITCH; i++) begin
      acc = acc + $urandom_range(2000, 65536 / n);
      if (acc > 65536 || (i == n - 1 && $urandom_range(0, 1) == 1)) acc = 65536;
      t[i] = CFG_DATA_W'(acc);
    end
    apply_setup(CFG_DATA_W'(n), CFG_DATA_W'($urandom_range(0, 15)), t[0], t[1], t[2], t[3],
                CFG_DATA_W'($urandom_range(0, 65536)));
  endtask

  function automatic in_word_t stride_word();
    in_word_t w;
    w.time_step      = TS_W'($urandom_range(500, 30000));
    w.gait_rate      = RATE_W'($urandom_range(128, 2048));
    w.contact_flag   = ($urandom_range(0, 2) != 0);
    w.lookahead_time = TS_W'($urandom_range(0, 300000));
    w.restart        = ($urandom_range(0, 49) == 0);
    return w;
  endfunction

  function automatic in_word_t noise_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  task automatic run_gait_phase(input int items);
    for (int k = 0; k < items; k++) begin
      if (k % 36 == 0) calm <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 88) send_word(stride_word());
      else send_word(noise_word());
    end
  endtask

  task automatic test_default_gait();
    tick(20'd0, 16'd0, 1'b0, 20'd0, 1'b0);
    tick(20'd131072, 16'd256, 1'b0, 20'd0, 1'b0);
    tick(20'd262144, 16'd256, 1'b0, 20'hFFFFF, 1'b0);
    tick(20'd262144, 16'd256, 1'b1, 20'd4096, 1'b0);
    tick(20'd65536, 16'd256, 1'b1, 20'd0, 1'b0);
    tick(20'd327680, 16'd256, 1'b1, 20'd0, 1'b0);
    tick(20'hFFFFF, 16'hFFFF, 1'b1, 20'hFFFFF, 1'b0);
    tick(20'hFFFFF, 16'hFFFF, 1'b1, 20'hFFFFF, 1'b1);
    tick(20'd0, 16'd0, 1'b0, 20'd0, 1'b1);
  endtask

  task automatic test_corner_patterns();
    wait_idle();
    apply_setup(17'd1, 17'b0001, 17'd0, 17'h10000, 17'h10000, 17'h10000, 17'd0);
    tick(20'd0, 16'd0, 1'b1, 20'd0, 1'b1);
    tick(20'd131072, 16'd256, 1'b0, 20'd0, 1'b0);
    tick(20'd131072, 16'd256, 1'b1, 20'd655360, 1'b0);
    wait_idle();
    apply_setup(17'd2, 17'b0010, 17'd32768, 17'd16384, 17'h10000, 17'h10000, 17'd0);
    tick(20'd655360, 16'd256, 1'b0, 20'd0, 1'b1);
    tick(20'd131072, 16'd256, 1'b1, 20'd0, 1'b0);
    tick(20'd0, 16'd0, 1'b0, 20'd0, 1'b1);
    wait_idle();
    apply_setup(17'd0, 17'b1110, 17'h1FFFF, 17'd0, 17'h10000, 17'h10000, 17'h10000);
    tick(20'hFFFFF, 16'h0200, 1'b0, 20'd0, 1'b1);
    tick(20'hFFFFF, 16'h0100, 1'b1, 20'hFFFFF, 1'b0);
    wait_idle();
    apply_setup(17'd7, 17'b1010, 17'd8192, 17'd16384, 17'd32768, 17'h10000, 17'd58982);
    tick(20'd0, 16'd0, 1'b0, 20'd0, 1'b1);
    tick(20'd163840, 16'd256, 1'b1, 20'd131072, 1'b0);
    tick(20'd163840, 16'd256, 1'b1, 20'd262144, 1'b0);
    tick(20'd262144, 16'd512, 1'b0, 20'd524288, 1'b0);
    tick(20'd262144, 16'd512, 1'b1, 20'd0, 1'b0);
  endtask

  task automatic test_random_gaits();
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      case (ph)
        3: apply_setup(17'd1, 17'hF, 17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'd0);
        5: apply_setup(17'd4, 17'h0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        7: apply_setup(17'd0, 17'hA, 17'd0, 17'd0, 17'd0, 17'd0, 17'h10000);
        8: apply_setup(17'd7, 17'h5, 17'd16384, 17'd32768, 17'd49152, 17'h10000, 17'd32768);
        default: pick_gait_setup();
      endcase
      run_gait_phase(72);
    end
    calm <= 1'b0;
  endtask

  initial begin
    reset_gait();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_gait();
    test_corner_patterns();
    test_random_gaits();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
